// ----- design/text_console_writer_unit_assert.svh -----
// assertion macros for the text console writer unit
// used by the sequencer and the datapath; no other dependencies
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcw: same-cycle check failed");

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcw: next-cycle check failed");

`else

`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tcw_pkg.sv -----
// shared constants, codes and types of the text console writer unit
// no dependencies
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CX_W   = COL_W + 1;

	// item field widths
	localparam int ACT_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int ATTR_W = 8;
	localparam int CELL_W = ATTR_W + CHAR_W;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

	// micro-operations driving the datapath
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_PUT     = 4'd1,
		OP_CPINIT  = 4'd2,
		OP_COPY    = 4'd3,
		OP_FINIT   = 4'd4,
		OP_CLRINIT = 4'd5,
		OP_FILL    = 4'd6,
		OP_DONE    = 4'd7,
		OP_RDREQ   = 4'd8,
		OP_RDCAP   = 4'd9,
		OP_RSTINIT = 4'd10
	} uop_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NONE    = 3'd0,
		C_ALWAYS  = 3'd1,
		C_NSTART  = 3'd2,
		C_PUT     = 3'd3,
		C_CLEAR   = 3'd4,
		C_READ    = 3'd5,
		C_NSCROLL = 3'd6,
		C_NLAST   = 3'd7
	} ucond_t;

	localparam int UPC_W = 5;

	// program labels
	localparam logic [UPC_W-1:0] L_IDLE  = 5'd0;
	localparam logic [UPC_W-1:0] L_DISP  = 5'd1;
	localparam logic [UPC_W-1:0] L_DISP2 = 5'd2;
	localparam logic [UPC_W-1:0] L_DISP3 = 5'd3;
	localparam logic [UPC_W-1:0] L_NOP   = 5'd4;
	localparam logic [UPC_W-1:0] L_PUT   = 5'd5;
	localparam logic [UPC_W-1:0] L_CPINI = 5'd6;
	localparam logic [UPC_W-1:0] L_COPY  = 5'd7;
	localparam logic [UPC_W-1:0] L_FINI  = 5'd8;
	localparam logic [UPC_W-1:0] L_CLR   = 5'd9;
	localparam logic [UPC_W-1:0] L_FILL  = 5'd10;
	localparam logic [UPC_W-1:0] L_DONE  = 5'd11;
	localparam logic [UPC_W-1:0] L_RD    = 5'd12;
	localparam logic [UPC_W-1:0] L_RDCAP = 5'd13;
	localparam logic [UPC_W-1:0] L_RST   = 5'd14;
	localparam logic [UPC_W-1:0] L_RFILL = 5'd15;
	localparam logic [UPC_W-1:0] L_RDONE = 5'd16;

	typedef struct packed {
		uop_t             op;
		ucond_t           cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		uop_t op;
		logic accept;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic act_put;
		logic act_clear;
		logic act_read;
		logic need_scroll;
		logic last;
	} stat_t;

endpackage

// ----- design/tcw_screen_ram.sv -----
// screen store: one write port, one read port with registered read data
// depends on tcw_pkg
module tcw_screen_ram
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem_q [CELL_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/tcw_useq.sv -----
// microcode sequencer: program rom, step counter and jump logic
// depends on tcw_pkg and the assertion macro header
`include "text_console_writer_unit_assert.svh"

module tcw_useq
	import tcw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	logic [UPC_W-1:0] upc_q;
	uword_t           word;
	logic             jump;

	// control program
	function automatic uword_t ucode(input logic [UPC_W-1:0] a);
		uword_t w;
		unique case (a)
			L_IDLE:  w = '{OP_NONE,    C_NSTART,  L_IDLE};
			L_DISP:  w = '{OP_NONE,    C_PUT,     L_PUT};
			L_DISP2: w = '{OP_NONE,    C_CLEAR,   L_CLR};
			L_DISP3: w = '{OP_NONE,    C_READ,    L_RD};
			L_NOP:   w = '{OP_NONE,    C_ALWAYS,  L_DONE};
			L_PUT:   w = '{OP_PUT,     C_NSCROLL, L_DONE};
			L_CPINI: w = '{OP_CPINIT,  C_NONE,    L_IDLE};
			L_COPY:  w = '{OP_COPY,    C_NLAST,   L_COPY};
			L_FINI:  w = '{OP_FINIT,   C_ALWAYS,  L_FILL};
			L_CLR:   w = '{OP_CLRINIT, C_NONE,    L_IDLE};
			L_FILL:  w = '{OP_FILL,    C_NLAST,   L_FILL};
			L_DONE:  w = '{OP_DONE,    C_ALWAYS,  L_IDLE};
			L_RD:    w = '{OP_RDREQ,   C_NONE,    L_IDLE};
			L_RDCAP: w = '{OP_RDCAP,   C_ALWAYS,  L_DONE};
			L_RST:   w = '{OP_RSTINIT, C_NONE,    L_IDLE};
			L_RFILL: w = '{OP_FILL,    C_NLAST,   L_RFILL};
			L_RDONE: w = '{OP_NONE,    C_ALWAYS,  L_IDLE};
			default: w = '{OP_NONE,    C_ALWAYS,  L_IDLE};
		endcase
		return w;
	endfunction

	assign word = ucode(upc_q);
	assign busy = (upc_q != L_IDLE);

	// jump condition select
	always_comb begin
		unique case (word.cond)
			C_NONE:    jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NSTART:  jump = !start;
			C_PUT:     jump = stat.act_put;
			C_CLEAR:   jump = stat.act_clear;
			C_READ:    jump = stat.act_read;
			C_NSCROLL: jump = !stat.need_scroll;
			C_NLAST:   jump = !stat.last;
			default:   jump = 1'b0;
		endcase
	end

	assign ctrl.op     = word.op;
	assign ctrl.accept = (upc_q == L_IDLE) && start;

	// step counter, starting with the store clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= L_RST;
		end else if (jump) begin
			upc_q <= word.target;
		end else begin
			upc_q <= upc_q + UPC_W'(1);
		end
	end

	`TCW_ASSERT_NXT(a_accept_dispatch, clk, arst_n, ctrl.accept, upc_q == L_DISP)
	`TCW_ASSERT_NXT(a_done_to_idle, clk, arst_n, word.op == OP_DONE, !busy)

endmodule

// ----- design/tcw_datapath.sv -----
// datapath: cursor, attribute, sweep counter, result registers and screen store
// depends on tcw_pkg, tcw_screen_ram and the assertion macro header
`include "text_console_writer_unit_assert.svh"

module tcw_datapath
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	input  logic [ACT_W-1:0]  action,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_data,
	output logic              done,
	output logic [POS_W-1:0]  cursor_position,
	output logic [CELL_W-1:0] cell_value,
	output logic              scrolled
);

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ACT_W-1:0]  action_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] end_q;
	logic [CELL_W-1:0] fill_q;
	logic [CELL_W-1:0] cell_value_q;
	logic              scrolled_q;

	logic              is_bs, is_tab, is_lf, is_cr;
	logic [CX_W-1:0]   col_x, ncol_raw;
	logic              wrap, row_step, need_scroll, last, idx_ok;
	logic [COL_W-1:0]  ncol, wcol;
	logic [ROW_W-1:0]  nrow;
	logic              wr_put;
	logic [ADDR_W-1:0] put_addr;
	logic [CELL_W-1:0] put_data, blank;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// control byte decode
	assign is_bs  = (ch_q == CH_BS);
	assign is_tab = (ch_q == CH_TAB);
	assign is_lf  = (ch_q == CH_LF);
	assign is_cr  = (ch_q == CH_CR);

	// next cursor for a put
	always_comb begin
		col_x = CX_W'(col_q);
		if (is_lf || is_cr) begin
			ncol_raw = '0;
		end else if (is_tab) begin
			ncol_raw = (col_x + CX_W'(4)) & ~CX_W'(3);
		end else if (is_bs) begin
			ncol_raw = (col_q != '0) ? col_x - CX_W'(1) : col_x;
		end else begin
			ncol_raw = col_x + CX_W'(1);
		end
	end

	assign wrap        = (ncol_raw >= CX_W'(COLUMNS));
	assign ncol        = wrap ? '0 : COL_W'(ncol_raw);
	assign row_step    = is_lf || wrap;
	assign need_scroll = row_step && (row_q == ROW_W'(ROWS - 1));
	assign nrow        = (row_step && !need_scroll) ? row_q + ROW_W'(1) : row_q;

	// cell write for a put
	assign blank    = {attr_q, CH_SPACE};
	assign wr_put   = !(is_lf || is_cr || is_tab) && (!is_bs || (col_q != '0));
	assign wcol     = is_bs ? col_q - COL_W'(1) : col_q;
	assign put_addr = ADDR_W'(32'(row_q) * COLUMNS + 32'(wcol));
	assign put_data = is_bs ? blank : {attr_q, ch_q};

	assign last   = (addr_q == end_q);
	assign idx_ok = (32'(idx_q) < CELL_COUNT);

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		unique case (ctrl.op)
			OP_PUT: begin
				ram_we    = wr_put;
				ram_waddr = put_addr;
				ram_wdata = put_data;
			end
			OP_FILL: begin
				ram_we = 1'b1;
			end
			OP_CPINIT: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(COLUMNS);
			end
			OP_COPY: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_re    = !last;
				ram_raddr = addr_q + ADDR_W'(COLUMNS + 1);
			end
			OP_RDREQ: begin
				ram_re    = idx_ok;
				ram_raddr = ADDR_W'(idx_q);
			end
			default: begin
			end
		endcase
	end

	tcw_screen_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// cursor and attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			attr_q <= RESET_ATTR;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			unique case (ctrl.op)
				OP_PUT: begin
					row_q <= nrow;
					col_q <= ncol;
				end
				OP_CLRINIT: begin
					row_q <= '0;
					col_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// item capture, sweep counter and result registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			action_q     <= action;
			ch_q         <= char_code;
			idx_q        <= cell_index;
			scrolled_q   <= 1'b0;
			cell_value_q <= '0;
		end
		unique case (ctrl.op) inside
			OP_PUT: begin
				scrolled_q <= need_scroll;
			end
			OP_CPINIT: begin
				addr_q <= '0;
				end_q  <= ADDR_W'((ROWS - 1) * COLUMNS - 1);
			end
			OP_FINIT: begin
				addr_q <= ADDR_W'((ROWS - 1) * COLUMNS);
				end_q  <= ADDR_W'(CELL_COUNT - 1);
				fill_q <= blank;
			end
			OP_CLRINIT: begin
				addr_q <= '0;
				end_q  <= ADDR_W'(CELL_COUNT - 1);
				fill_q <= blank;
			end
			OP_RSTINIT: begin
				addr_q <= '0;
				end_q  <= ADDR_W'(CELL_COUNT - 1);
				fill_q <= {RESET_ATTR, CH_SPACE};
			end
			OP_FILL, OP_COPY: begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			OP_RDCAP: begin
				cell_value_q <= idx_ok ? ram_rdata : '0;
			end
			default: begin
			end
		endcase
	end

	// status to the sequencer
	assign stat.act_put     = (action_q == ACT_PUT);
	assign stat.act_clear   = (action_q == ACT_CLEAR);
	assign stat.act_read    = (action_q == ACT_READ);
	assign stat.need_scroll = need_scroll;
	assign stat.last        = last;

	// result ports
	assign done            = (ctrl.op == OP_DONE);
	assign cursor_position = POS_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign cell_value      = cell_value_q;
	assign scrolled        = scrolled_q;

	`TCW_ASSERT_IMP(a_cursor_range, clk, arst_n, done, (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
	`TCW_ASSERT_IMP(a_scroll_bottom, clk, arst_n, done && scrolled, row_q == ROW_W'(ROWS - 1))
	`TCW_ASSERT_IMP(a_cell_only_read, clk, arst_n, done && (cell_value != '0), action_q == ACT_READ)

endmodule

// ----- design/text_console_writer_unit.sv -----
// Text-mode console writer. An item is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high and must be taken
// then, as the block cannot hold it. A clear screen fills every cell with a
// blank, and a put that scrolls copies each row up by one and blanks the last
// row; the microcode program does these sweeps, walking the screen store
// one cell per cycle through its single write port. After reset the block
// stays busy while it blanks the store; attribute writes are accepted at any
// time, cfg_ready is always high.
//
// top level: joins the microcode sequencer and the datapath
// depends on tcw_pkg, tcw_useq and tcw_datapath
module text_console_writer_unit
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ACT_W-1:0]  action,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	output logic              done,
	output logic [POS_W-1:0]  cursor_position,
	output logic [CELL_W-1:0] cell_value,
	output logic              scrolled,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ATTR_W-1:0] cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	// attribute register is always writable
	assign cfg_ready = 1'b1;

	tcw_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	tcw_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.stat            (stat),
		.action          (action),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.cursor_position (cursor_position),
		.cell_value      (cell_value),
		.scrolled        (scrolled)
	);

endmodule
